[hdl/cdf_pkg.sv]
// ----------------------------------------------------------------------------
// cdf_pkg
// Shared types, tags and codes of the chunk stream deframer.
// ----------------------------------------------------------------------------
package cdf_pkg;

  localparam logic [31:0] TAG_OLD_MAGIC = 32'h414E494D;
  localparam logic [31:0] TAG_OLD_HDR   = 32'h41484452;
  localparam logic [31:0] TAG_NEW_MAGIC = 32'h53414E4D;
  localparam logic [31:0] TAG_NEW_HDR   = 32'h53484452;
  localparam logic [31:0] TAG_FLHD      = 32'h464C4844;
  localparam logic [31:0] TAG_WAVE      = 32'h57617665;
  localparam logic [31:0] TAG_BL16      = 32'h426C3136;
  localparam logic [31:0] TAG_ANNO      = 32'h414E4E4F;
  localparam logic [31:0] TAG_FRME      = 32'h46524D45;
  localparam logic [31:0] OLD_HDR_MIN   = 32'd774;
  localparam logic [31:0] NEW_HDR_MIN   = 32'd14;
  localparam logic [31:0] ALL_ONES      = 32'hFFFFFFFF;
  localparam int          NUM_FIELDS    = 8;
  localparam int          TDATA_W       = 80;

  localparam logic [2:0] KIND_VIDEO  = 3'd0;
  localparam logic [2:0] KIND_AUDIO  = 3'd1;
  localparam logic [2:0] KIND_PAL    = 3'd2;
  localparam logic [2:0] KIND_HEADER = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  localparam logic [1:0] ERR_INVALID = 2'd0;
  localparam logic [1:0] ERR_SHORT   = 2'd1;
  localparam logic [1:0] ERR_HEADER  = 2'd2;

  localparam logic [1:0] PT_FRME  = 2'd0;
  localparam logic [1:0] PT_VIDEO = 2'd1;
  localparam logic [1:0] PT_WAVE  = 2'd2;
  localparam logic [1:0] PT_SKIP  = 2'd3;

  typedef enum logic [4:0] {
    PH_MAGIC, PH_MOVSZ, PH_HTAG, PH_HSIZE, PH_OSUB, PH_ONFR, PH_OPAD, PH_PAL,
    PH_OSKIP, PH_NSUB, PH_NNFR, PH_NPAD1, PH_NW, PH_NH, PH_NPAD2, PH_NSKIP,
    PH_FTAG, PH_FSIZE, PH_SUBTAG, PH_SUBSIZE, PH_WRATE, PH_WCHAN, PH_SUBSKIP,
    PH_FSKIP, PH_BTAG, PH_BSIZE, PH_BSKIP, PH_PKT, PH_HALT
  } phase_t;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [7:0]  index;
    logic        valid;
    logic        first;
    logic        last;
    logic [31:0] dur;
    logic [1:0]  err;
  } result_t;

  // results caused by one input item
  typedef struct packed {
    logic    has_one;
    result_t one;
    logic    burst;
    logic    tail_end;
  } desc_t;

  // header fields, stable once the header is done
  typedef struct packed {
    logic        fv;
    logic [15:0] sub;
    logic [31:0] frames;
    logic [15:0] width;
    logic [15:0] height;
    logic        found;
    logic [31:0] rate;
    logic [31:0] chans;
  } hdr_t;

endpackage

[hdl/cdf_parser.sv]
// ----------------------------------------------------------------------------
// cdf_parser
// Byte-wise header parser and chunk deframer state machine.
// ----------------------------------------------------------------------------
module cdf_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               stream_end,
  output cdf_pkg::desc_t     desc,
  output logic               desc_any,
  output cdf_pkg::hdr_t      hdr
);

  cdf_pkg::phase_t phase, phase_next;
  logic [31:0] word_shift, word_shift_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic        format_version, format_version_next;
  logic [15:0] sub_version, sub_version_next;
  logic [31:0] frame_total, frame_total_next;
  logic [15:0] frame_width, frame_width_next;
  logic [15:0] frame_height, frame_height_next;
  logic [31:0] audio_rate, audio_rate_next;
  logic [31:0] audio_channels, audio_channels_next;
  logic        audio_found, audio_found_next;
  logic [31:0] flhd_size, flhd_size_next;
  logic [33:0] flhd_consumed, flhd_consumed_next;
  logic [1:0]  packet_type, packet_type_next;
  logic [31:0] duration_word, duration_word_next;
  logic [7:0]  palette_index, palette_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= cdf_pkg::PH_MAGIC;
      word_shift      <= '0;
      byte_count      <= '0;
      chunk_remaining <= '0;
      format_version  <= 1'b0;
      sub_version     <= '0;
      frame_total     <= '0;
      frame_width     <= '0;
      frame_height    <= '0;
      audio_rate      <= '0;
      audio_channels  <= '0;
      audio_found     <= 1'b0;
      flhd_size       <= '0;
      flhd_consumed   <= '0;
      packet_type     <= '0;
      duration_word   <= '0;
      palette_index   <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      word_shift      <= word_shift_next;
      byte_count      <= byte_count_next;
      chunk_remaining <= chunk_remaining_next;
      format_version  <= format_version_next;
      sub_version     <= sub_version_next;
      frame_total     <= frame_total_next;
      frame_width     <= frame_width_next;
      frame_height    <= frame_height_next;
      audio_rate      <= audio_rate_next;
      audio_channels  <= audio_channels_next;
      audio_found     <= audio_found_next;
      flhd_size       <= flhd_size_next;
      flhd_consumed   <= flhd_consumed_next;
      packet_type     <= packet_type_next;
      duration_word   <= duration_word_next;
      palette_index   <= palette_index_next;
    end
  end

  assign hdr = '{fv: format_version, sub: sub_version, frames: frame_total,
                 width: frame_width, height: frame_height, found: audio_found,
                 rate: audio_rate, chans: audio_channels};

  always_comb begin
    logic [31:0] ws_be, ws_le, minsz, w8;
    logic [4:0]  cnt1;
    logic [3:0]  bc_inc;
    logic [31:0] cr_dec;
    logic        do_walk, do_hdr, do_fail, cr_zero;
    logic [1:0]  fail_code;
    logic [34:0] cons8;
    logic [33:0] rem;
    ws_be  = {word_shift[23:0], data_byte};
    ws_le  = word_shift | (32'(data_byte) << {byte_count[1:0], 3'b000});
    cnt1   = {1'b0, byte_count} + 5'd1;
    bc_inc = (byte_count == 4'hF) ? byte_count : byte_count + 4'd1;
    cr_dec = chunk_remaining - 32'd1;
    minsz  = format_version ? cdf_pkg::NEW_HDR_MIN : cdf_pkg::OLD_HDR_MIN;
    w8     = 32'd0;
    do_walk = 1'b0;
    do_hdr  = 1'b0;
    do_fail = 1'b0;
    fail_code = cdf_pkg::ERR_INVALID;
    cr_zero = 1'b0;
    cons8 = '0;
    rem   = '0;

    phase_next           = phase;
    word_shift_next      = word_shift;
    byte_count_next      = byte_count;
    chunk_remaining_next = chunk_remaining;
    format_version_next  = format_version;
    sub_version_next     = sub_version;
    frame_total_next     = frame_total;
    frame_width_next     = frame_width;
    frame_height_next    = frame_height;
    audio_rate_next      = audio_rate;
    audio_channels_next  = audio_channels;
    audio_found_next     = audio_found;
    flhd_size_next       = flhd_size;
    flhd_consumed_next   = flhd_consumed;
    packet_type_next     = packet_type;
    duration_word_next   = duration_word;
    palette_index_next   = palette_index;
    desc = '0;

    if (phase == cdf_pkg::PH_HALT) begin
      // halted: absorb items silently
    end else if (stream_end) begin
      if (phase < cdf_pkg::PH_BTAG) begin
        do_fail = 1'b1;
        fail_code = cdf_pkg::ERR_HEADER;
      end else begin
        desc.has_one = 1'b1;
        desc.one.kind = cdf_pkg::KIND_END;
        if (phase == cdf_pkg::PH_PKT) begin
          if (packet_type == cdf_pkg::PT_WAVE) begin
            if (byte_count < 4'd13) begin
              do_fail = 1'b1;
              fail_code = cdf_pkg::ERR_SHORT;
            end else begin
              desc.one.kind = cdf_pkg::KIND_AUDIO;
              desc.one.last = 1'b1;
              desc.one.dur  = duration_word;
              desc.tail_end = 1'b1;
            end
          end else if (byte_count != 4'd0) begin
            desc.one.kind = cdf_pkg::KIND_VIDEO;
            desc.one.last = 1'b1;
            desc.one.dur  = duration_word;
            desc.tail_end = 1'b1;
          end
        end
        phase_next = cdf_pkg::PH_HALT;
      end
    end else begin
      // default take: count and shift big-endian, callers override
      byte_count_next = bc_inc;
      word_shift_next = ws_be;
      unique case (phase)
        cdf_pkg::PH_MAGIC: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_MOVSZ;
            if (ws_be == cdf_pkg::TAG_OLD_MAGIC) format_version_next = 1'b0;
            else if (ws_be == cdf_pkg::TAG_NEW_MAGIC) format_version_next = 1'b1;
            else do_fail = 1'b1;
          end
        end
        cdf_pkg::PH_MOVSZ: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_HTAG;
          end
        end
        cdf_pkg::PH_HTAG: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_HSIZE;
            if (ws_be != (format_version ? cdf_pkg::TAG_NEW_HDR : cdf_pkg::TAG_OLD_HDR))
              do_fail = 1'b1;
          end
        end
        cdf_pkg::PH_HSIZE: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            if (ws_be < minsz) do_fail = 1'b1;
            chunk_remaining_next = ws_be - minsz;
            phase_next = format_version ? cdf_pkg::PH_NSUB : cdf_pkg::PH_OSUB;
          end
        end
        cdf_pkg::PH_OSUB, cdf_pkg::PH_NSUB: begin
          word_shift_next = ws_le;
          if (cnt1 >= 5'd2) begin
            byte_count_next = '0; word_shift_next = '0;
            sub_version_next = ws_le[15:0];
            phase_next = (phase == cdf_pkg::PH_OSUB) ? cdf_pkg::PH_ONFR : cdf_pkg::PH_NNFR;
          end
        end
        cdf_pkg::PH_ONFR, cdf_pkg::PH_NNFR: begin
          word_shift_next = ws_le;
          if (cnt1 >= ((phase == cdf_pkg::PH_ONFR) ? 5'd2 : 5'd4)) begin
            byte_count_next = '0; word_shift_next = '0;
            if (ws_le == 32'd0) do_fail = 1'b1;
            frame_total_next = ws_le;
            phase_next = (phase == cdf_pkg::PH_ONFR) ? cdf_pkg::PH_OPAD : cdf_pkg::PH_NPAD1;
          end
        end
        cdf_pkg::PH_OPAD: begin
          if (cnt1 >= 5'd2) begin
            byte_count_next = '0; word_shift_next = '0;
            palette_index_next = '0;
            phase_next = cdf_pkg::PH_PAL;
          end
        end
        cdf_pkg::PH_PAL: begin
          if (cnt1 >= 5'd3) begin
            desc.has_one     = 1'b1;
            desc.one.kind    = cdf_pkg::KIND_PAL;
            desc.one.value   = {8'd0, ws_be[23:0]};
            desc.one.index   = palette_index;
            desc.one.valid   = 1'b1;
            desc.one.first   = (palette_index == 8'd0);
            desc.one.last    = (palette_index == 8'hFF);
            if (palette_index == 8'hFF) begin
              if (chunk_remaining == 32'd0) do_hdr = 1'b1;
              else phase_next = cdf_pkg::PH_OSKIP;
            end else begin
              palette_index_next = palette_index + 8'd1;
              byte_count_next = '0; word_shift_next = '0;
            end
          end
        end
        cdf_pkg::PH_OSKIP, cdf_pkg::PH_FSKIP: begin
          byte_count_next = byte_count; word_shift_next = word_shift;
          chunk_remaining_next = cr_dec;
          if (cr_dec == 32'd0) do_hdr = 1'b1;
        end
        cdf_pkg::PH_NPAD1: begin
          if (cnt1 >= 5'd2) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_NW;
          end
        end
        cdf_pkg::PH_NW, cdf_pkg::PH_NH: begin
          word_shift_next = ws_le;
          if (cnt1 >= 5'd2) begin
            byte_count_next = '0; word_shift_next = '0;
            if (phase == cdf_pkg::PH_NW) begin
              frame_width_next = ws_le[15:0];
              phase_next = cdf_pkg::PH_NH;
            end else begin
              frame_height_next = ws_le[15:0];
              phase_next = cdf_pkg::PH_NPAD2;
            end
          end
        end
        cdf_pkg::PH_NPAD2: begin
          if (cnt1 >= 5'd2) begin
            if (chunk_remaining == 32'd0) begin
              byte_count_next = '0; word_shift_next = '0;
              phase_next = cdf_pkg::PH_FTAG;
            end else begin
              phase_next = cdf_pkg::PH_NSKIP;
            end
          end
        end
        cdf_pkg::PH_NSKIP: begin
          byte_count_next = byte_count; word_shift_next = word_shift;
          chunk_remaining_next = cr_dec;
          if (cr_dec == 32'd0) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_FTAG;
          end
        end
        cdf_pkg::PH_FTAG: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_FSIZE;
            if (ws_be != cdf_pkg::TAG_FLHD) do_fail = 1'b1;
          end
        end
        cdf_pkg::PH_FSIZE: begin
          if (cnt1 >= 5'd4) begin
            flhd_size_next = ws_be;
            flhd_consumed_next = '0;
            do_walk = 1'b1;
          end
        end
        cdf_pkg::PH_SUBTAG: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            if (ws_be == cdf_pkg::TAG_WAVE) packet_type_next = cdf_pkg::PT_WAVE;
            else if (ws_be == cdf_pkg::TAG_BL16 || ws_be == cdf_pkg::TAG_ANNO)
              packet_type_next = cdf_pkg::PT_VIDEO;
            else packet_type_next = cdf_pkg::PT_SKIP;
            phase_next = cdf_pkg::PH_SUBSIZE;
          end
        end
        cdf_pkg::PH_SUBSIZE: begin
          if (cnt1 >= 5'd4) begin
            if (packet_type == cdf_pkg::PT_SKIP) begin
              do_fail = 1'b1;
            end else begin
              flhd_consumed_next = flhd_consumed + 34'd8 + 34'(ws_be);
              if (packet_type == cdf_pkg::PT_WAVE) begin
                audio_found_next = 1'b1;
                w8 = ws_be - 32'd8;
                chunk_remaining_next = (ws_be > 32'd8) ? w8 : 32'd0;
                byte_count_next = '0; word_shift_next = '0;
                phase_next = cdf_pkg::PH_WRATE;
              end else begin
                chunk_remaining_next = ws_be;
                cr_zero = (ws_be == 32'd0);
                if (cr_zero) do_walk = 1'b1;
                else phase_next = cdf_pkg::PH_SUBSKIP;
              end
            end
          end
        end
        cdf_pkg::PH_WRATE, cdf_pkg::PH_WCHAN: begin
          word_shift_next = ws_le;
          if (cnt1 >= 5'd4) begin
            if (ws_le == 32'd0) do_fail = 1'b1;
            if (phase == cdf_pkg::PH_WRATE) begin
              audio_rate_next = ws_le;
              byte_count_next = '0; word_shift_next = '0;
              phase_next = cdf_pkg::PH_WCHAN;
            end else begin
              audio_channels_next = ws_le;
              if (chunk_remaining == 32'd0) do_walk = 1'b1;
              else phase_next = cdf_pkg::PH_SUBSKIP;
            end
          end
        end
        cdf_pkg::PH_SUBSKIP: begin
          byte_count_next = byte_count; word_shift_next = word_shift;
          chunk_remaining_next = cr_dec;
          if (cr_dec == 32'd0) do_walk = 1'b1;
        end
        cdf_pkg::PH_BTAG: begin
          if (cnt1 >= 5'd4) begin
            byte_count_next = '0; word_shift_next = '0;
            if (ws_be == cdf_pkg::TAG_FRME) packet_type_next = cdf_pkg::PT_FRME;
            else if (ws_be == cdf_pkg::TAG_BL16) packet_type_next = cdf_pkg::PT_VIDEO;
            else if (ws_be == cdf_pkg::TAG_WAVE) packet_type_next = cdf_pkg::PT_WAVE;
            else packet_type_next = cdf_pkg::PT_SKIP;
            phase_next = cdf_pkg::PH_BSIZE;
          end
        end
        cdf_pkg::PH_BSIZE: begin
          if (cnt1 >= 5'd4) begin
            if (packet_type == cdf_pkg::PT_SKIP ||
                (packet_type == cdf_pkg::PT_FRME && format_version)) begin
              if (packet_type == cdf_pkg::PT_SKIP && ws_be != 32'd0) begin
                chunk_remaining_next = ws_be;
                phase_next = cdf_pkg::PH_BSKIP;
              end else begin
                byte_count_next = '0; word_shift_next = '0;
                phase_next = cdf_pkg::PH_BTAG;
              end
            end else if (packet_type == cdf_pkg::PT_WAVE && ws_be < 32'd13) begin
              do_fail = 1'b1;
            end else begin
              duration_word_next = (packet_type == cdf_pkg::PT_VIDEO) ? 32'd1 : 32'd0;
              byte_count_next = '0; word_shift_next = '0;
              if (ws_be == 32'd0) begin
                desc.has_one   = 1'b1;
                desc.one.kind  = cdf_pkg::KIND_VIDEO;
                desc.one.first = 1'b1;
                desc.one.last  = 1'b1;
                desc.one.dur   = duration_word_next;
                phase_next = cdf_pkg::PH_BTAG;
              end else begin
                chunk_remaining_next = ws_be;
                phase_next = cdf_pkg::PH_PKT;
              end
            end
          end
        end
        cdf_pkg::PH_BSKIP: begin
          byte_count_next = byte_count; word_shift_next = word_shift;
          chunk_remaining_next = cr_dec;
          if (cr_dec == 32'd0) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_BTAG;
          end
        end
        cdf_pkg::PH_PKT: begin
          word_shift_next = word_shift;
          if (packet_type == cdf_pkg::PT_WAVE) begin
            if (byte_count < 4'd4) begin
              duration_word_next = {duration_word[23:0], data_byte};
            end else if (byte_count >= 4'd8 && byte_count < 4'd12) begin
              word_shift_next = ws_be;
              if (byte_count == 4'd11 && duration_word == cdf_pkg::ALL_ONES)
                duration_word_next = ws_be;
            end
          end
          desc.has_one   = 1'b1;
          desc.one.kind  = (packet_type == cdf_pkg::PT_WAVE) ? cdf_pkg::KIND_AUDIO
                                                             : cdf_pkg::KIND_VIDEO;
          desc.one.value = 32'(data_byte);
          desc.one.valid = 1'b1;
          desc.one.first = (byte_count == 4'd0);
          desc.one.last  = (chunk_remaining == 32'd1);
          desc.one.dur   = desc.one.last ? duration_word_next : 32'd0;
          chunk_remaining_next = cr_dec;
          if (desc.one.last) begin
            byte_count_next = '0; word_shift_next = '0;
            phase_next = cdf_pkg::PH_BTAG;
          end
        end
        default: begin
          byte_count_next = byte_count; word_shift_next = word_shift;
        end
      endcase
    end

    // walk the FLHD subchunks with the updated counters
    if (do_walk) begin
      cons8 = {1'b0, flhd_consumed_next} + 35'd8;
      if (audio_found_next || cons8 >= 35'(flhd_size_next)) begin
        rem = (flhd_consumed_next >= 34'(flhd_size_next)) ? 34'd0
              : 34'(flhd_size_next) - flhd_consumed_next;
        if (rem == 34'd0) begin
          do_hdr = 1'b1;
        end else begin
          chunk_remaining_next = rem[31:0];
          phase_next = cdf_pkg::PH_FSKIP;
        end
      end else begin
        byte_count_next = '0; word_shift_next = '0;
        phase_next = cdf_pkg::PH_SUBTAG;
      end
    end
    if (do_hdr) begin
      desc.burst = 1'b1;
      byte_count_next = '0; word_shift_next = '0;
      phase_next = cdf_pkg::PH_BTAG;
    end
    if (do_fail) begin
      desc = '0;
      desc.has_one  = 1'b1;
      desc.one.kind = cdf_pkg::KIND_ERROR;
      desc.one.err  = fail_code;
      phase_next = cdf_pkg::PH_HALT;
    end
  end

  assign desc_any = desc.has_one | desc.burst;

endmodule

[hdl/cdf_emit.sv]
// ----------------------------------------------------------------------------
// cdf_emit
// Result register that sends one item's results, one per res_ready cycle.
// ----------------------------------------------------------------------------
module cdf_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  cdf_pkg::desc_t  desc_in,
  input  logic            desc_any,
  input  cdf_pkg::hdr_t   hdr,
  output logic            free,
  output logic            res_valid,
  input  logic            res_ready,
  output cdf_pkg::result_t res
);

  logic           held;
  cdf_pkg::desc_t desc;
  logic [3:0]     step;
  logic [3:0]     total;
  logic [2:0]     fld;
  logic           final_res;

  assign total = {3'd0, desc.has_one} + (desc.burst ? 4'd8 : 4'd0)
               + {3'd0, desc.tail_end};
  assign final_res = (step == total - 4'd1);
  assign free = !held || (res_ready && final_res);
  assign res_valid = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      step <= '0;
    end else if (load) begin
      held <= desc_any;
      step <= '0;
    end else if (held && res_ready) begin
      // drop the register once its last result is taken
      if (final_res) held <= 1'b0;
      else step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc <= desc_in;
  end

  always_comb begin
    logic [3:0] off;
    off = step - {3'd0, desc.has_one};
    fld = off[2:0];
    res = '0;
    if (desc.has_one && step == 4'd0) begin
      res = desc.one;
    end else if (desc.burst) begin
      res.kind  = cdf_pkg::KIND_HEADER;
      res.index = {5'd0, fld};
      res.valid = 1'b1;
      res.first = (fld == 3'd0);
      res.last  = (fld == 3'(cdf_pkg::NUM_FIELDS - 1));
      case (fld)
        3'd0: res.value = {31'd0, hdr.fv};
        3'd1: res.value = {16'd0, hdr.sub};
        3'd2: res.value = hdr.frames;
        3'd3: res.value = {16'd0, hdr.width};
        3'd4: res.value = {16'd0, hdr.height};
        3'd5: res.value = {31'd0, hdr.found};
        3'd6: res.value = hdr.rate;
        default: res.value = hdr.chans;
      endcase
    end else begin
      res.kind = cdf_pkg::KIND_END;
    end
  end

endmodule

[hdl/chunk_stream_deframer.sv]
// ----------------------------------------------------------------------------
// chunk_stream_deframer
// Parses a chunked movie container header and deframes its body chunks.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata                     tuser        tlast
// s_*       in   data_byte[7:0]            stream_end   -
// m_*       out  value,index,valid,first,  kind[2:0]    packet_last
//                duration,error_code
//
// One input byte is taken per cycle while s_tready is high; the parser
// state machine decides its results in the same cycle and loads them into
// the result register. An item that causes several results (palette entry
// plus header burst, or packet close plus end) holds s_tready low until
// the result register has sent all of them, up to nine results in all.
// rst is synchronous and active high; it restarts the parse at file magic.
// A stall on m_tready holds the result register and backs up into s_tready.
// After an error or end result the block absorbs every item until reset.
module chunk_stream_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] data_byte
  input  logic [0:0]                   s_tuser,   // [0] stream_end
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [31:0] data_value, [39:32] item_index, [40] byte_valid,
  // [41] packet_first, [73:42] packet_duration, [75:74] error_code, rest 0
  output logic [cdf_pkg::TDATA_W-1:0]  m_tdata,
  output logic [2:0]                   m_tuser,   // [2:0] kind
  output logic                         m_tlast    // packet_last
);

  logic             fire;
  cdf_pkg::desc_t   desc;
  logic             desc_any;
  cdf_pkg::hdr_t    hdr;
  cdf_pkg::result_t res;

  // advance the parser only when the result register can take its results
  assign fire = s_tvalid && s_tready;

  cdf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (s_tdata),
    .stream_end (s_tuser[0]),
    .desc       (desc),
    .desc_any   (desc_any),
    .hdr        (hdr)
  );

  cdf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .desc_in   (desc),
    .desc_any  (desc_any),
    .hdr       (hdr),
    .free      (s_tready),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {4'd0, res.err, res.dur, res.first, res.valid, res.index, res.value};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
